// File: rtl/rms3_pkg.sv
package rms3_pkg;

  // Field and register widths
  localparam int GEOM_W    = 11;
  localparam int ROW_CNT_W = GEOM_W + 1;
  localparam int GAIN_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int OUT_W     = 16;
  localparam int SUM_W     = 12;
  localparam int COUNT_W   = 4;
  localparam int DIVR_W    = 12;
  localparam int PROD_W    = SUM_W + GAIN_W;
  localparam int DIV_CNT_W = $clog2(PROD_W);
  localparam int WIN_CELLS = 9;

  // Geometry limits and reset values
  localparam int MAX_ROW_LENGTH_DEF = 1024;
  localparam int MAX_ROWS           = 1024;
  localparam int ROW_LENGTH_RESET   = 1024;
  localparam int ROW_TOTAL_RESET    = 1024;
  localparam logic [GAIN_W-1:0] HEIGHT_GAIN_RESET = 16'd256;

  // Configuration port
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_LENGTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_TOTAL   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT_GAIN = 2'd2;

  // Request opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic shift;
    logic sum;
    logic mul;
    logic div_step;
    logic load_out;
  } rms3_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic take;
    logic emit;
    logic div_last;
    logic out_free;
  } rms3_sts_t;

endpackage

// File: rtl/raster_3x3_mean_smoother.sv
// Channel   Handshake              Payload
// in_       in_valid / in_ready    in_op, in_height_byte (one request per sample or drain)
// out_      out_valid / out_ready  out_smoothed_height, out_frame_end
// cfg       psel / penable / pready pwrite, paddr, pwdata, prdata (APB-style, 32-bit)
//
// An emitting request runs through accept, line-buffer shift, masked sum, gain
// multiply, the divider steps (one quotient bit each, divisor count*255) and
// the output load. A request that emits nothing ends after the shift; one the
// frame state ignores (drain before frame end, sample after it) gets no accept.
// Reset is synchronous (rst_n low): positions, window and registers restart.
// A waiting result holds only the final load of the next one until out_ready.
module raster_3x3_mean_smoother #(
  parameter int MAX_ROW_LENGTH = rms3_pkg::MAX_ROW_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [rms3_pkg::BYTE_W-1:0]   in_height_byte,
  // Results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rms3_pkg::OUT_W-1:0]    out_smoothed_height,
  output logic                          out_frame_end,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rms3_pkg::CFG_AW-1:0]   paddr,
  input  logic [rms3_pkg::CFG_DW-1:0]   pwdata,
  output logic [rms3_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  import rms3_pkg::*;

  // Reset geometry, held within the line-buffer depth and the row limit
  localparam logic [GEOM_W-1:0] RL_RESET = GEOM_W'((MAX_ROW_LENGTH < ROW_LENGTH_RESET) ?
                                                   MAX_ROW_LENGTH : ROW_LENGTH_RESET);
  localparam logic [GEOM_W-1:0] RT_RESET = GEOM_W'((MAX_ROWS < ROW_TOTAL_RESET) ?
                                                   MAX_ROWS : ROW_TOTAL_RESET);

  logic [GEOM_W-1:0] row_length_r, row_total_r;
  logic [GAIN_W-1:0] height_gain_r;
  logic [GEOM_W-1:0] wr_geom, rl_sat, rt_sat;
  logic [REG_IDX_W-1:0] reg_idx;
  logic              cfg_wr, frame_clr;

  rms3_cmd_t cmd;
  rms3_sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign wr_geom = pwdata[GEOM_W-1:0];

  // Saturate geometry writes on the low 11 data bits: zero reads as one, oversize as the limit
  always_comb begin
    if (wr_geom == '0) begin
      rl_sat = GEOM_W'(1);
    end else if (32'(wr_geom) > MAX_ROW_LENGTH) begin
      rl_sat = GEOM_W'(MAX_ROW_LENGTH);
    end else begin
      rl_sat = wr_geom;
    end
    if (wr_geom == '0) begin
      rt_sat = GEOM_W'(1);
    end else if (32'(wr_geom) > MAX_ROWS) begin
      rt_sat = GEOM_W'(MAX_ROWS);
    end else begin
      rt_sat = wr_geom;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r  <= RL_RESET;
      row_total_r   <= RT_RESET;
      height_gain_r <= HEIGHT_GAIN_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROW_LENGTH:  row_length_r  <= rl_sat;
        REG_ROW_TOTAL:   row_total_r   <= rt_sat;
        REG_HEIGHT_GAIN: height_gain_r <= pwdata[GAIN_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // A geometry write starts a fresh frame
  assign frame_clr = cfg_wr && ((reg_idx == REG_ROW_LENGTH) || (reg_idx == REG_ROW_TOTAL));

  always_comb begin
    case (reg_idx)
      REG_ROW_LENGTH:  prdata = CFG_DW'(row_length_r);
      REG_ROW_TOTAL:   prdata = CFG_DW'(row_total_r);
      REG_HEIGHT_GAIN: prdata = CFG_DW'(height_gain_r);
      default:         prdata = '0;
    endcase
  end

  rms3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rms3_dp #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .frame_clr           (frame_clr),
    .row_length          (row_length_r),
    .row_total           (row_total_r),
    .height_gain         (height_gain_r),
    .in_op               (in_op),
    .in_height_byte      (in_height_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_smoothed_height (out_smoothed_height),
    .out_frame_end       (out_frame_end)
  );

endmodule

// File: rtl/rms3_ram.sv
module rms3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/rms3_ctrl.sv
module rms3_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rms3_pkg::rms3_sts_t sts,
  output rms3_pkg::rms3_cmd_t cmd
);

  import rms3_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_SUM   = 6'b000100,
    S_MUL   = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && sts.take) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = sts.emit ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/rms3_dp.sv
module rms3_dp #(
  parameter int MAX_ROW_LENGTH = rms3_pkg::MAX_ROW_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rms3_pkg::rms3_cmd_t           cmd,
  output rms3_pkg::rms3_sts_t           sts,
  input  logic                          frame_clr,
  input  logic [rms3_pkg::GEOM_W-1:0]   row_length,
  input  logic [rms3_pkg::GEOM_W-1:0]   row_total,
  input  logic [rms3_pkg::GAIN_W-1:0]   height_gain,
  input  logic                          in_op,
  input  logic [rms3_pkg::BYTE_W-1:0]   in_height_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rms3_pkg::OUT_W-1:0]    out_smoothed_height,
  output logic                          out_frame_end
);

  import rms3_pkg::*;

  localparam int LINE_AW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;

  // Stream and result positions
  logic [GEOM_W-1:0]    in_col_r;
  logic [ROW_CNT_W-1:0] in_row_r;
  logic [GEOM_W-1:0]    out_col_r;
  logic [GEOM_W-1:0]    out_row_r;

  logic [BYTE_W-1:0] sample_r;
  logic              lag_r;
  logic [BYTE_W-1:0] win_r [WIN_CELLS];

  logic [BYTE_W-1:0] up_rd, mid_rd;
  logic [LINE_AW-1:0] line_addr;

  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [DIVR_W-1:0]    divisor_r, divisor_nxt;
  logic [COUNT_W-1:0]   count_nxt;
  logic [PROD_W-1:0]    div_q_r;
  logic [DIVR_W-1:0]    div_rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DIVR_W:0]      rem_sh, rem_diff;
  logic                 rem_ge;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic              out_fe_r;

  logic [GEOM_W-1:0] rl_m1, rt_m1;
  logic              complete, lag_now, last_pos;
  logic [2:0]        row_ok, col_ok;
  logic [SUM_W-1:0]  row_sum [3];

  assign rl_m1     = row_length - GEOM_W'(1);
  assign rt_m1     = row_total - GEOM_W'(1);
  assign complete  = in_row_r >= {1'b0, row_total};
  assign lag_now   = (in_row_r >= ROW_CNT_W'(2)) ||
                     ((in_row_r == ROW_CNT_W'(1)) && (in_col_r != '0));
  assign last_pos  = (out_row_r == rt_m1) && (out_col_r == rl_m1);
  assign line_addr = LINE_AW'(in_col_r);

  // Line buffers: read at accept, write back the rotated column on shift
  rms3_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_ROW_LENGTH)
  ) u_upper_line (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (line_addr),
    .wdata (mid_rd),
    .re    (cmd.accept),
    .raddr (line_addr),
    .rdata (up_rd)
  );

  rms3_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_ROW_LENGTH)
  ) u_middle_line (
    .clk   (clk),
    .we    (cmd.shift),
    .waddr (line_addr),
    .wdata (sample_r),
    .re    (cmd.accept),
    .raddr (line_addr),
    .rdata (mid_rd)
  );

  // Masked neighbourhood sum and divisor
  always_comb begin
    row_ok = {out_row_r != rt_m1, 1'b1, out_row_r != '0};
    col_ok = {out_col_r != rl_m1, 1'b1, out_col_r != '0};
    count_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = '0;
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          row_sum[r] = row_sum[r] + SUM_W'(win_r[r*3+c]);
          count_nxt  = count_nxt + COUNT_W'(1);
        end
      end
    end
    sum_nxt     = row_sum[0] + row_sum[1] + row_sum[2];
    divisor_nxt = {count_nxt, 8'd0} - DIVR_W'(count_nxt);
  end

  // One restoring division step
  always_comb begin
    rem_sh   = {div_rem_r, div_q_r[PROD_W-1]};
    rem_ge   = rem_sh >= {1'b0, divisor_r};
    rem_diff = rem_sh - {1'b0, divisor_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= (in_op == OP_DRAIN) ? '0 : in_height_byte;
      lag_r    <= lag_now;
    end
    if (cmd.sum) begin
      sum_r     <= sum_nxt;
      divisor_r <= divisor_nxt;
    end
    if (cmd.mul) begin
      div_q_r   <= sum_r * height_gain;
      div_rem_r <= '0;
    end else if (cmd.div_step) begin
      div_q_r   <= {div_q_r[PROD_W-2:0], rem_ge};
      div_rem_r <= rem_ge ? rem_diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
    end
    if (cmd.load_out) begin
      out_data_r <= div_q_r[OUT_W-1:0];
      out_fe_r   <= last_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.mul) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // Positions and window; a frame end or geometry write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n || frame_clr || (cmd.load_out && last_pos)) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      for (int i = 0; i < WIN_CELLS; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cmd.shift) begin
        if (in_col_r == rl_m1) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + ROW_CNT_W'(1);
        end else begin
          in_col_r <= in_col_r + GEOM_W'(1);
        end
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]   <= win_r[r*3+1];
          win_r[r*3+1] <= win_r[r*3+2];
        end
        win_r[2] <= up_rd;
        win_r[5] <= mid_rd;
        win_r[8] <= sample_r;
      end
      if (cmd.load_out) begin
        if (out_col_r == rl_m1) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + GEOM_W'(1);
        end else begin
          out_col_r <= out_col_r + GEOM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.take     = (in_op == OP_DRAIN) == complete;
  assign sts.emit     = lag_r;
  assign sts.div_last = div_cnt_r == DIV_CNT_W'(PROD_W - 1);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_smoothed_height = out_data_r;
  assign out_frame_end       = out_fe_r;

  a_in_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r < row_length) else $error("stream column beyond row length");

  a_out_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_row_r < row_total) else $error("result row beyond frame");

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready)) else $error("result overwritten");

  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out)) else $error("result without load");

endmodule
